FILE: hdl/dfpc_pkg.sv
package dfpc_pkg;

    // item field widths
    localparam int LIGHT_W = 16;
    localparam int PED_W   = 25;     // dark / bias, signed Q17.8
    localparam int FLAT_W  = 22;     // flat, unsigned Q6.16
    localparam int CNT_W   = 25;
    localparam int OUT_W   = 16;
    localparam int STAT_W  = 2;

    // configuration port
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam int MAX_PIXELS_DEF = 16777216;

    // register reset values (flat limits are 0.05 and 20.0 in Q6.16)
    localparam logic [OUT_W-1:0]  SAT_RST       = 16'd65535;
    localparam logic              HAS_BIAS_RST  = 1'b1;
    localparam logic [FLAT_W-1:0] FLAT_LOW_RST  = 22'd3277;
    localparam logic [FLAT_W-1:0] FLAT_HIGH_RST = 22'd1310720;

    typedef enum logic [1:0] {
        REG_SATURATION = 2'd0,
        REG_DARK_BIAS  = 2'd1,
        REG_FLAT_LOW   = 2'd2,
        REG_FLAT_HIGH  = 2'd3
    } reg_idx_t;

    typedef enum logic [STAT_W-1:0] {
        ST_NORMAL    = 2'd0,
        ST_BAD_FLAT  = 2'd1,
        ST_CLIP_LOW  = 2'd2,
        ST_CLIP_HIGH = 2'd3
    } status_t;

endpackage

FILE: hdl/dfpc_in_if.sv
interface dfpc_in_if;
    import dfpc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [LIGHT_W-1:0]       light_value;
    logic signed [PED_W-1:0]  dark_value;
    logic signed [PED_W-1:0]  bias_value;
    logic [FLAT_W-1:0]        flat_value;
    logic                     frame_start;

    modport source (
        output valid, light_value, dark_value, bias_value, flat_value, frame_start,
        input  ready
    );

    modport sink (
        input  valid, light_value, dark_value, bias_value, flat_value, frame_start,
        output ready
    );

endinterface

FILE: hdl/dfpc_out_if.sv
interface dfpc_out_if;
    import dfpc_pkg::*;

    logic                valid;
    logic                ready;
    logic [OUT_W-1:0]    calibrated_value;
    logic [STAT_W-1:0]   pixel_status;
    logic [CNT_W-1:0]    invalid_flat_total;
    logic [CNT_W-1:0]    clipped_low_total;
    logic [CNT_W-1:0]    clipped_high_total;

    modport source (
        output valid, calibrated_value, pixel_status, invalid_flat_total,
               clipped_low_total, clipped_high_total,
        input  ready
    );

    modport sink (
        input  valid, calibrated_value, pixel_status, invalid_flat_total,
               clipped_low_total, clipped_high_total,
        output ready
    );

endinterface

FILE: hdl/dark_flat_pixel_calibrate_unit.sv
// Dark subtraction and flat-field correction, one pixel item per clock.
// A result passes through two front stages, one classify stage and sixteen
// radix-2 divider stages before it is presented.
// Throughput: one item per cycle; the whole pipe holds when the output stalls.
// Reset (rst_n, async, active low): pipe empty, counters zero, registers
// at their documented defaults.
module dark_flat_pixel_calibrate_unit #(
    parameter int MAX_PIXELS = dfpc_pkg::MAX_PIXELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    dfpc_in_if.sink                       pix_in,
    dfpc_out_if.source                    pix_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dfpc_pkg::APB_AW-1:0]   paddr,
    input  logic [dfpc_pkg::APB_DW-1:0]   pwdata,
    output logic [dfpc_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import dfpc_pkg::*;

    // counters saturate at the smaller of MAX_PIXELS and all-ones
    localparam longint CNT_MAX = (longint'(1) << CNT_W) - 1;
    localparam logic [CNT_W-1:0] CNT_CAP =
        (longint'(MAX_PIXELS) < CNT_MAX) ? CNT_W'(MAX_PIXELS) : CNT_W'(CNT_MAX);

    localparam int SIG_W  = 27;              // light*256 - offset, signed
    localparam int MAG_W  = SIG_W - 1;       // positive signal magnitude
    localparam int PROD_W = OUT_W + FLAT_W;  // saturation * flat
    localparam int NUM_W  = MAG_W + 10;      // 512*s + flat
    localparam int DVS_W  = FLAT_W + 1;      // 2*flat
    localparam int QBITS  = OUT_W;           // quotient never exceeds saturation
    localparam int NDIV   = QBITS;

    //------------------------------------------------------------------
    // Configuration registers
    //------------------------------------------------------------------
    logic [OUT_W-1:0]  sat_reg;
    logic              has_bias_reg;
    logic [FLAT_W-1:0] flat_low_reg;
    logic [FLAT_W-1:0] flat_high_reg;
    logic              cfg_wr;
    reg_idx_t          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg       <= SAT_RST;
            has_bias_reg  <= HAS_BIAS_RST;
            flat_low_reg  <= FLAT_LOW_RST;
            flat_high_reg <= FLAT_HIGH_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_SATURATION: sat_reg       <= pwdata[OUT_W-1:0];
                REG_DARK_BIAS:  has_bias_reg  <= pwdata[0];
                REG_FLAT_LOW:   flat_low_reg  <= pwdata[FLAT_W-1:0];
                REG_FLAT_HIGH:  flat_high_reg <= pwdata[FLAT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_SATURATION: prdata = APB_DW'(sat_reg);
            REG_DARK_BIAS:  prdata = APB_DW'(has_bias_reg);
            REG_FLAT_LOW:   prdata = APB_DW'(flat_low_reg);
            REG_FLAT_HIGH:  prdata = APB_DW'(flat_high_reg);
            default:        prdata = '0;
        endcase
    end

    //------------------------------------------------------------------
    // Pipeline advance: every stage moves when the output slot frees up.
    //------------------------------------------------------------------
    logic adv;
    logic div_valid_reg [0:NDIV];

    assign adv          = !div_valid_reg[NDIV] || pix_out.ready;
    assign pix_in.ready = adv;

    //------------------------------------------------------------------
    // Stage 1: flat bounds check and signal = light*256 - offset (Q.8)
    //------------------------------------------------------------------
    logic                     flat_bad;
    logic signed [PED_W:0]    offset;
    logic signed [SIG_W-1:0]  signal_next;

    logic                     s1_valid_reg;
    logic                     s1_fs_reg;
    logic                     s1_bad_reg;
    logic signed [SIG_W-1:0]  s1_sig_reg;
    logic [FLAT_W-1:0]        s1_flat_reg;

    always_comb
    begin
        flat_bad = (pix_in.flat_value == '0) ||
                   (pix_in.flat_value < flat_low_reg) ||
                   (pix_in.flat_value > flat_high_reg);
        offset = {pix_in.dark_value[PED_W-1], pix_in.dark_value} +
                 (has_bias_reg ? '0 : {pix_in.bias_value[PED_W-1], pix_in.bias_value});
        signal_next = $signed({3'b000, pix_in.light_value, 8'h00}) -
                      {offset[PED_W], offset};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= pix_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_fs_reg   <= pix_in.frame_start;
            s1_bad_reg  <= flat_bad;
            s1_sig_reg  <= signal_next;
            s1_flat_reg <= pix_in.flat_value;
        end
    end

    //------------------------------------------------------------------
    // Stage 2: sign test, saturation * flat product for the high clip
    //------------------------------------------------------------------
    logic                     s2_valid_reg;
    logic                     s2_fs_reg;
    logic                     s2_bad_reg;
    logic                     s2_pos_reg;
    logic [MAG_W-1:0]         s2_mag_reg;
    logic [FLAT_W-1:0]        s2_flat_reg;
    logic [PROD_W-1:0]        s2_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_fs_reg   <= s1_fs_reg;
            s2_bad_reg  <= s1_bad_reg;
            s2_pos_reg  <= !s1_sig_reg[SIG_W-1] && (s1_sig_reg != '0);
            s2_mag_reg  <= s1_sig_reg[MAG_W-1:0];
            s2_flat_reg <= s1_flat_reg;
            s2_prod_reg <= PROD_W'(sat_reg) * PROD_W'(s1_flat_reg);
        end
    end

    //------------------------------------------------------------------
    // Stage 3: classify, update frame counters, set up the division
    //------------------------------------------------------------------
    status_t           st_next;
    logic              over_sat;
    logic [NUM_W-1:0]  numer;
    logic [CNT_W-1:0]  inv_base, low_base, high_base;
    logic [CNT_W-1:0]  inv_cnt_next, low_cnt_next, high_cnt_next;
    logic [CNT_W-1:0]  inv_cnt_reg, low_cnt_reg, high_cnt_reg;

    always_comb
    begin
        over_sat = PROD_W'({s2_mag_reg, 8'h00}) >= s2_prod_reg;
        if (s2_bad_reg)
            st_next = ST_BAD_FLAT;
        else if (!s2_pos_reg)
            st_next = ST_CLIP_LOW;
        else if (over_sat)
            st_next = ST_CLIP_HIGH;
        else
            st_next = ST_NORMAL;

        // round half up: (512*s + flat) / (2*flat)
        numer = NUM_W'({s2_mag_reg, 9'h000}) + NUM_W'(s2_flat_reg);

        // frame_start clears before this pixel is counted
        inv_base  = s2_fs_reg ? '0 : inv_cnt_reg;
        low_base  = s2_fs_reg ? '0 : low_cnt_reg;
        high_base = s2_fs_reg ? '0 : high_cnt_reg;
        inv_cnt_next  = inv_base +
                        CNT_W'((st_next == ST_BAD_FLAT) && (inv_base < CNT_CAP));
        low_cnt_next  = low_base +
                        CNT_W'((st_next == ST_CLIP_LOW) && (low_base < CNT_CAP));
        high_cnt_next = high_base +
                        CNT_W'((st_next == ST_CLIP_HIGH) && (high_base < CNT_CAP));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_cnt_reg  <= '0;
            low_cnt_reg  <= '0;
            high_cnt_reg <= '0;
        end
        else if (adv && s2_valid_reg)
        begin
            inv_cnt_reg  <= inv_cnt_next;
            low_cnt_reg  <= low_cnt_next;
            high_cnt_reg <= high_cnt_next;
        end
    end

    //------------------------------------------------------------------
    // Divider: restoring, one quotient bit per stage. Stage 0 holds the
    // top numerator bits as the partial remainder; it is already below
    // the divisor because the quotient fits in QBITS bits.
    //------------------------------------------------------------------
    status_t           div_st_reg   [0:NDIV];
    logic [DVS_W-1:0]  div_rem_reg  [0:NDIV];
    logic [QBITS-1:0]  div_low_reg  [0:NDIV];
    logic [QBITS-1:0]  div_quot_reg [0:NDIV];
    logic [DVS_W-1:0]  div_dvs_reg  [0:NDIV];
    logic [CNT_W-1:0]  div_inv_reg  [0:NDIV];
    logic [CNT_W-1:0]  div_low_cnt_reg  [0:NDIV];
    logic [CNT_W-1:0]  div_high_cnt_reg [0:NDIV];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_valid_reg[0] <= 1'b0;
        else if (adv)
            div_valid_reg[0] <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            div_st_reg[0]       <= st_next;
            div_rem_reg[0]      <= DVS_W'(numer[NUM_W-1:QBITS]);
            div_low_reg[0]      <= numer[QBITS-1:0];
            div_quot_reg[0]     <= '0;
            div_dvs_reg[0]      <= {s2_flat_reg, 1'b0};
            div_inv_reg[0]      <= inv_cnt_next;
            div_low_cnt_reg[0]  <= low_cnt_next;
            div_high_cnt_reg[0] <= high_cnt_next;
        end
    end

    for (genvar k = 1; k <= NDIV; k++)
    begin : g_div
        logic [DVS_W:0] trial;
        logic           ge;

        assign trial = {div_rem_reg[k-1], div_low_reg[k-1][QBITS-1]};
        assign ge    = trial >= {1'b0, div_dvs_reg[k-1]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                div_valid_reg[k] <= 1'b0;
            else if (adv)
                div_valid_reg[k] <= div_valid_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                div_st_reg[k]       <= div_st_reg[k-1];
                div_rem_reg[k]      <= ge ? DVS_W'(trial - {1'b0, div_dvs_reg[k-1]})
                                          : trial[DVS_W-1:0];
                div_low_reg[k]      <= {div_low_reg[k-1][QBITS-2:0], 1'b0};
                div_quot_reg[k]     <= {div_quot_reg[k-1][QBITS-2:0], ge};
                div_dvs_reg[k]      <= div_dvs_reg[k-1];
                div_inv_reg[k]      <= div_inv_reg[k-1];
                div_low_cnt_reg[k]  <= div_low_cnt_reg[k-1];
                div_high_cnt_reg[k] <= div_high_cnt_reg[k-1];
            end
        end
    end

    //------------------------------------------------------------------
    // Output: last divider stage is the output register
    //------------------------------------------------------------------
    always_comb
    begin
        case (div_st_reg[NDIV])
            ST_NORMAL:    pix_out.calibrated_value = div_quot_reg[NDIV];
            ST_CLIP_HIGH: pix_out.calibrated_value = sat_reg;
            default:      pix_out.calibrated_value = '0;
        endcase
    end

    assign pix_out.valid              = div_valid_reg[NDIV];
    assign pix_out.pixel_status       = div_st_reg[NDIV];
    assign pix_out.invalid_flat_total = div_inv_reg[NDIV];
    assign pix_out.clipped_low_total  = div_low_cnt_reg[NDIV];
    assign pix_out.clipped_high_total = div_high_cnt_reg[NDIV];

endmodule

FILE: tb/dark_flat_pixel_calibrate_unit_tb.sv
`timescale 1ns / 100ps

module dark_flat_pixel_calibrate_unit_tb;
    import dfpc_pkg::*;

    // counters stop at the smaller of MAX_PIXELS and the 25-bit ceiling
    localparam logic [CNT_W-1:0] CNT_CAP =
        (MAX_PIXELS_DEF < 33554431) ? CNT_W'(MAX_PIXELS_DEF) : 25'h1FFFFFF;
    localparam longint PED_MIN = -(64'sd1 << 24);
    localparam longint PED_MAX = (64'sd1 << 24) - 1;
    localparam int DIR_ROWS = 29;
    localparam int PHASES = 12;
    localparam int SQUEEZE_CYCLES = 400;

    // one pixel item as the block takes it
    typedef struct {
        logic [LIGHT_W-1:0]      light;
        logic signed [PED_W-1:0] dark;
        logic signed [PED_W-1:0] bias;
        logic [FLAT_W-1:0]       flat;
        logic                    frame_start;
    } pixel_t;

    // one calibrated item as the block returns it
    typedef struct {
        logic [OUT_W-1:0] value;
        status_t          status;
        logic [CNT_W-1:0] bad_flat;
        logic [CNT_W-1:0] low_clip;
        logic [CNT_W-1:0] high_clip;
    } calib_t;

    typedef enum {ROW_PIXEL, ROW_WRITE} row_kind_t;

    // directed row: either a register write or a pixel; value and status
    // are typed in where obvious, otherwise the predictor supplies them
    typedef struct {
        row_kind_t    kind;
        reg_idx_t     reg_sel;
        int unsigned  wdata;
        logic [15:0]  light;
        int           dark;
        int           bias;
        logic [21:0]  flat;
        bit           frame_start;
        bit           typed;
        logic [15:0]  exp_value;
        status_t      exp_status;
    } stim_row_t;

    // register setting and traffic shape of one random phase
    typedef struct {
        logic [15:0] sat;
        logic        dark_bias;
        logic [21:0] low;
        logic [21:0] high;
        int          tx_pct;
        int          rx_pct;
        int          count;
        bit          squeeze;
    } phase_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    dfpc_in_if  pixels_in ();
    dfpc_out_if pixels_out ();

    dark_flat_pixel_calibrate_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pixels_in),
        .pix_out (pixels_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor copy of the registers
    logic [15:0] cfg_sat;
    logic        cfg_dark_bias;
    logic [21:0] cfg_flat_low;
    logic [21:0] cfg_flat_high;

    // predictor copy of the frame statistics
    logic [CNT_W-1:0] bad_flat_cnt;
    logic [CNT_W-1:0] low_clip_cnt;
    logic [CNT_W-1:0] high_clip_cnt;

    calib_t expected_pixels[$];
    int     mismatch_count;
    int     tx_idle_pct;
    int     rx_stall_pct;
    bit     rx_hold;
    event   hold_go;

    // directed items, default registers at the top
    stim_row_t dir_rows [0:DIR_ROWS-1] = '{
        // zero signal clips low, also opens a frame
        '{ROW_PIXEL, REG_SATURATION, 0, 0, 0, 0, 65536, 1, 1, 0, ST_CLIP_LOW},
        // zero flat
        '{ROW_PIXEL, REG_SATURATION, 0, 500, 0, 0, 0, 0, 1, 0, ST_BAD_FLAT},
        // just under / at the low flat bound
        '{ROW_PIXEL, REG_SATURATION, 0, 100, 0, 0, 3276, 0, 1, 0, ST_BAD_FLAT},
        '{ROW_PIXEL, REG_SATURATION, 0, 100, 0, 0, 3277, 0, 0, 0, ST_NORMAL},
        // widest signal at the high flat bound
        '{ROW_PIXEL, REG_SATURATION, 0, 65535, -16777216, 16777215, 1310720, 0,
          0, 0, ST_NORMAL},
        '{ROW_PIXEL, REG_SATURATION, 0, 65535, 0, 0, 1310721, 0, 1, 0, ST_BAD_FLAT},
        // exactly at saturation
        '{ROW_PIXEL, REG_SATURATION, 0, 65535, 0, 0, 65536, 0, 1, 65535, ST_CLIP_HIGH},
        // largest dark drives the signal negative
        '{ROW_PIXEL, REG_SATURATION, 0, 65535, 16777215, 0, 65536, 0, 1, 0, ST_CLIP_LOW},
        // half a count rounds up, just under half rounds down
        '{ROW_PIXEL, REG_SATURATION, 0, 0, -128, 0, 65536, 0, 1, 1, ST_NORMAL},
        '{ROW_PIXEL, REG_SATURATION, 0, 0, -127, 0, 65536, 0, 1, 0, ST_NORMAL},
        // largest flat, new frame
        '{ROW_PIXEL, REG_SATURATION, 0, 1234, 5000, -3000, 4194303, 1, 1, 0, ST_BAD_FLAT},
        // bias now added to the offset
        '{ROW_WRITE, REG_DARK_BIAS, 0, 0, 0, 0, 0, 0, 0, 0, ST_NORMAL},
        '{ROW_PIXEL, REG_SATURATION, 0, 1000, 25600, 25600, 65536, 0, 1, 800, ST_NORMAL},
        '{ROW_PIXEL, REG_SATURATION, 0, 0, 0, -16777216, 65536, 0, 1, 65535, ST_CLIP_HIGH},
        // low limit 0: zero flat still invalid, flat of one lsb valid
        '{ROW_WRITE, REG_FLAT_LOW, 0, 0, 0, 0, 0, 0, 0, 0, ST_NORMAL},
        '{ROW_PIXEL, REG_SATURATION, 0, 500, 0, 0, 0, 0, 1, 0, ST_BAD_FLAT},
        '{ROW_PIXEL, REG_SATURATION, 0, 500, 0, 0, 1, 0, 1, 65535, ST_CLIP_HIGH},
        // crossed bounds reject everything
        '{ROW_WRITE, REG_FLAT_LOW, 2000000, 0, 0, 0, 0, 0, 0, 0, ST_NORMAL},
        '{ROW_PIXEL, REG_SATURATION, 0, 500, 0, 0, 1500000, 0, 1, 0, ST_BAD_FLAT},
        '{ROW_PIXEL, REG_SATURATION, 0, 500, 0, 0, 1000000, 0, 1, 0, ST_BAD_FLAT},
        '{ROW_WRITE, REG_FLAT_LOW, 3277, 0, 0, 0, 0, 0, 0, 0, ST_NORMAL},
        // zero saturation: any positive signal clips high to 0
        '{ROW_WRITE, REG_SATURATION, 0, 0, 0, 0, 0, 0, 0, 0, ST_NORMAL},
        '{ROW_PIXEL, REG_SATURATION, 0, 1, 0, 0, 65536, 0, 1, 0, ST_CLIP_HIGH},
        '{ROW_PIXEL, REG_SATURATION, 0, 0, 0, 0, 65536, 0, 1, 0, ST_CLIP_LOW},
        // 9.5 rounds up to the saturation level without clipping
        '{ROW_WRITE, REG_SATURATION, 10, 0, 0, 0, 0, 0, 0, 0, ST_NORMAL},
        '{ROW_PIXEL, REG_SATURATION, 0, 0, -2432, 0, 65536, 0, 1, 10, ST_NORMAL},
        '{ROW_PIXEL, REG_SATURATION, 0, 10, 0, 0, 65536, 0, 1, 10, ST_CLIP_HIGH},
        '{ROW_WRITE, REG_FLAT_HIGH, 4194303, 0, 0, 0, 0, 0, 0, 0, ST_NORMAL},
        '{ROW_PIXEL, REG_SATURATION, 0, 65535, -16777216, -16777216, 4194303, 1,
          0, 0, ST_NORMAL}
    };

    // sat, dark_has_bias, flat low, flat high, sender idle %, receiver stall %,
    // item count, long receiver hold-off
    phase_t phases [0:PHASES-1] = '{
        '{16'd65535, 1'b1, 22'd3277,    22'd1310720, 0,  0,  140, 1'b0},
        '{16'd65535, 1'b1, 22'd3277,    22'd1310720, 51, 0,  140, 1'b0},
        '{16'd65535, 1'b0, 22'd0,       22'd4194303, 0,  51, 140, 1'b0},
        '{16'd1,     1'b1, 22'd3277,    22'd1310720, 12, 12, 140, 1'b0},
        '{16'd4095,  1'b0, 22'd65536,   22'd131072,  0,  0,  140, 1'b1},
        '{16'd0,     1'b1, 22'd1,       22'd4194303, 51, 0,  140, 1'b0},
        '{16'd1000,  1'b0, 22'd3277,    22'd3277,    0,  51, 140, 1'b0},
        '{16'd65535, 1'b1, 22'd4194303, 22'd0,       12, 12, 80,  1'b0},
        '{16'd30000, 1'b0, 22'd0,       22'd65536,   0,  0,  140, 1'b0},
        '{16'd65535, 1'b1, 22'd4194303, 22'd4194303, 0,  51, 140, 1'b0},
        '{16'd512,   1'b1, 22'd16384,   22'd262144,  12, 12, 140, 1'b0},
        '{16'd65535, 1'b1, 22'd3277,    22'd1310720, 0,  0,  140, 1'b1}
    };

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        return (c < CNT_CAP) ? c + 1'b1 : c;
    endfunction

    // Expected result of one pixel; advances the frame statistics.
    // Signal stays exact in Q.8; the clip-high test and the rounded
    // quotient are done on integers scaled so nothing is lost.
    function automatic calib_t calibrate_pixel(input pixel_t p);
        calib_t r;
        longint fl;
        longint offset;
        longint signal;
        r.value = '0;
        r.status = ST_NORMAL;
        fl = longint'(p.flat);
        if (p.frame_start)
        begin
            bad_flat_cnt = '0;
            low_clip_cnt = '0;
            high_clip_cnt = '0;
        end
        if (p.flat == 0 || p.flat < cfg_flat_low || p.flat > cfg_flat_high)
        begin
            r.status = ST_BAD_FLAT;
            bad_flat_cnt = bump(bad_flat_cnt);
        end
        else
        begin
            offset = longint'(p.dark) + (cfg_dark_bias ? 64'sd0 : longint'(p.bias));
            signal = longint'(p.light) * 256 - offset;
            if (signal <= 0)
            begin
                r.status = ST_CLIP_LOW;
                low_clip_cnt = bump(low_clip_cnt);
            end
            else if (signal * 256 >= longint'(cfg_sat) * fl)
            begin
                r.value = cfg_sat;
                r.status = ST_CLIP_HIGH;
                high_clip_cnt = bump(high_clip_cnt);
            end
            else
                r.value = 16'((signal * 512 + fl) / (2 * fl));
        end
        r.bad_flat = bad_flat_cnt;
        r.low_clip = low_clip_cnt;
        r.high_clip = high_clip_cnt;
        return r;
    endfunction

    // Random pixel. Most items aim the signal at a chosen output level for
    // the current flat, so in-range rounding and the saturation edge get
    // real coverage; the rest keep fully random dark and bias.
    function automatic pixel_t make_pixel();
        pixel_t p;
        logic [31:0] rnd;
        longint fl;
        longint vmax;
        longint v;
        longint sig;
        longint lmin;
        longint offset;
        longint bias_v;
        longint dark_v;
        int unsigned pick;
        rnd = $urandom;
        p.light = rnd[15:0];
        rnd = $urandom;
        p.dark = rnd[24:0];
        rnd = $urandom;
        p.bias = rnd[24:0];
        p.frame_start = ($urandom_range(0, 49) == 0);

        pick = $urandom_range(0, 99);
        if (pick < 4)
            p.flat = '0;
        else if (pick < 10)
        begin
            rnd = $urandom;
            p.flat = rnd[21:0];
        end
        else if (pick < 18)
        begin
            // just around either bound; wraps at the ends of the field
            case ($urandom_range(0, 5))
                0: p.flat = cfg_flat_low - 1'b1;
                1: p.flat = cfg_flat_low;
                2: p.flat = cfg_flat_low + 1'b1;
                3: p.flat = cfg_flat_high - 1'b1;
                4: p.flat = cfg_flat_high;
                default: p.flat = cfg_flat_high + 1'b1;
            endcase
        end
        else if (cfg_flat_low <= cfg_flat_high)
            p.flat = 22'($urandom_range(cfg_flat_low, cfg_flat_high));
        else
        begin
            rnd = $urandom;
            p.flat = rnd[21:0];
        end

        if ($urandom_range(0, 99) < 70)
        begin
            fl = (p.flat == 0) ? 64'sd1 : longint'(p.flat);
            vmax = (longint'(30000000) * 256) / fl;
            if (vmax > longint'(cfg_sat) + 2)
                vmax = longint'(cfg_sat) + 2;
            v = longint'($urandom_range(0, 32'(vmax)));
            if (cfg_sat != 0 && $urandom_range(0, 4) == 0)
                v = longint'(cfg_sat) - 1 + longint'($urandom_range(0, 2));
            if ($urandom_range(0, 9) < 2)
                sig = ((2 * v + 1) * fl) / 512 + longint'($urandom_range(0, 2)) - 1;
            else
                sig = (v * fl) / 256 + longint'($urandom_range(0, 511)) - 256;
            lmin = (sig > 64'sd16777216) ? (sig - 16777216 + 255) / 256 : 64'sd0;
            if (lmin <= 65535)
            begin
                p.light = 16'($urandom_range(32'(lmin), 65535));
                offset = longint'(p.light) * 256 - sig;
                bias_v = cfg_dark_bias ? longint'(p.bias)
                                       : longint'($urandom_range(0, 2097152)) - 1048576;
                dark_v = cfg_dark_bias ? offset : offset - bias_v;
                if (dark_v >= PED_MIN && dark_v <= PED_MAX)
                begin
                    p.dark = dark_v[24:0];
                    p.bias = bias_v[24:0];
                end
            end
        end
        return p;
    endfunction

    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // APB read, entered and left at a falling edge; leaves the bus idle
    task automatic check_register(input reg_idx_t idx, input logic [31:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        compare_field($sformatf("register %s", idx.name()), want, prdata);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // APB write with read-back; the predictor keeps only the register's bits
    task automatic write_register(input reg_idx_t idx, input logic [31:0] data);
        logic [31:0] want;
        case (idx)
            REG_SATURATION:
            begin
                cfg_sat = data[15:0];
                want = {16'd0, data[15:0]};
            end
            REG_DARK_BIAS:
            begin
                cfg_dark_bias = data[0];
                want = {31'd0, data[0]};
            end
            REG_FLAT_LOW:
            begin
                cfg_flat_low = data[21:0];
                want = {10'd0, data[21:0]};
            end
            default:
            begin
                cfg_flat_high = data[21:0];
                want = {10'd0, data[21:0]};
            end
        endcase
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        check_register(idx, want);
    endtask

    // Offer one item, with random idle cycles first; the expectation is
    // queued at the edge that accepts it. Entered and left at a falling edge.
    task automatic send_pixel(input pixel_t p, input bit typed,
                              input logic [15:0] tv, input status_t ts);
        calib_t r;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            pixels_in.valid <= 1'b0;
            @(negedge clk);
        end
        pixels_in.valid <= 1'b1;
        pixels_in.light_value <= p.light;
        pixels_in.dark_value <= p.dark;
        pixels_in.bias_value <= p.bias;
        pixels_in.flat_value <= p.flat;
        pixels_in.frame_start <= p.frame_start;
        do @(posedge clk); while (!pixels_in.ready);
        r = calibrate_pixel(p);
        if (typed)
        begin
            r.value = tv;
            r.status = ts;
        end
        expected_pixels = {expected_pixels, r};
        @(negedge clk);
    endtask

    // stop offering and let every outstanding result come back
    task automatic drain_pipe();
        pixels_in.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        @(negedge clk);
    endtask

    // receiver: random stalls, plus the long hold-off when asked
    always @(negedge clk)
        pixels_out.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);

    // long receiver hold-off, counted here so the sender keeps pushing
    initial
    begin
        rx_hold = 1'b0;
        forever
        begin
            @(hold_go);
            rx_hold = 1'b1;
            repeat (SQUEEZE_CYCLES) @(posedge clk);
            rx_hold = 1'b0;
        end
    end

    // result checker: every accepted item against the oldest expectation
    always @(posedge clk)
    begin : score
        calib_t want;
        if (rst_n === 1'b1 && pixels_out.valid === 1'b1 && pixels_out.ready === 1'b1)
        begin
            if (expected_pixels.size() == 0)
            begin
                mismatch_count++;
                $display("%0t ns: unexpected item, value %0d status %0d", $time,
                         pixels_out.calibrated_value, pixels_out.pixel_status);
            end
            else
            begin
                want = expected_pixels.pop_front();
                compare_field("calibrated_value", 32'(want.value),
                              32'(pixels_out.calibrated_value));
                compare_field("pixel_status", 32'(want.status),
                              32'(pixels_out.pixel_status));
                compare_field("invalid_flat_total", 32'(want.bad_flat),
                              32'(pixels_out.invalid_flat_total));
                compare_field("clipped_low_total", 32'(want.low_clip),
                              32'(pixels_out.clipped_low_total));
                compare_field("clipped_high_total", 32'(want.high_clip),
                              32'(pixels_out.clipped_high_total));
            end
        end
    end

    initial
    begin : stimulus
        pixel_t p;
        stim_row_t row;
        phase_t ph;
        int i;
        int k;

        // everything known from time zero
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pixels_in.valid = 1'b0;
        pixels_in.light_value = '0;
        pixels_in.dark_value = '0;
        pixels_in.bias_value = '0;
        pixels_in.flat_value = '0;
        pixels_in.frame_start = 1'b0;
        pixels_out.ready = 1'b0;
        mismatch_count = 0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        cfg_sat = SAT_RST;
        cfg_dark_bias = HAS_BIAS_RST;
        cfg_flat_low = FLAT_LOW_RST;
        cfg_flat_high = FLAT_HIGH_RST;
        bad_flat_cnt = '0;
        low_clip_cnt = '0;
        high_clip_cnt = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // registers come out of reset at their defaults
        check_register(REG_SATURATION, 32'(SAT_RST));
        check_register(REG_DARK_BIAS, 32'(HAS_BIAS_RST));
        check_register(REG_FLAT_LOW, 32'(FLAT_LOW_RST));
        check_register(REG_FLAT_HIGH, 32'(FLAT_HIGH_RST));

        // directed table, no idling
        for (i = 0; i < DIR_ROWS; i++)
        begin
            row = dir_rows[i];
            if (row.kind == ROW_WRITE)
            begin
                drain_pipe();
                write_register(row.reg_sel, row.wdata);
            end
            else
            begin
                p.light = row.light;
                p.dark = row.dark[24:0];
                p.bias = row.bias[24:0];
                p.flat = row.flat;
                p.frame_start = row.frame_start;
                send_pixel(p, row.typed, row.exp_value, row.exp_status);
            end
        end

        // random phases; junk above each register's width must be dropped
        for (i = 0; i < PHASES; i++)
        begin
            ph = phases[i];
            drain_pipe();
            write_register(REG_SATURATION, {16'($urandom), ph.sat});
            write_register(REG_DARK_BIAS, {31'($urandom), ph.dark_bias});
            write_register(REG_FLAT_LOW, {10'($urandom), ph.low});
            write_register(REG_FLAT_HIGH, {10'($urandom), ph.high});
            tx_idle_pct = ph.tx_pct;
            rx_stall_pct = ph.rx_pct;
            // sender keeps offering while the output is held off,
            // so the pipe fills and back-pressures the input
            if (ph.squeeze)
                -> hold_go;
            for (k = 0; k < ph.count; k++)
                send_pixel(make_pixel(), 1'b0, '0, ST_NORMAL);
        end

        drain_pipe();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && expected_pixels.size() == 0)
            $display("dark_flat_pixel_calibrate_unit_tb: clean");
        else
            $display("dark_flat_pixel_calibrate_unit_tb: errors");
        $finish;
    end

    // hard stop far beyond the slowest legal run
    initial
    begin : watchdog
        #5_000_000;
        $display("dark_flat_pixel_calibrate_unit_tb: errors");
        $finish;
    end

endmodule
